[sv/assert_macros.svh]
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that expr holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error(msg);

// Check that cons follows ante in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds on the clock edge after ante.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/sblm_pkg.sv]
package sblm_pkg;

   // Access kinds
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_CHR   = 2'd2;

   // Result targets
   localparam logic [2:0] TGT_PRG_ROM = 3'd0;
   localparam logic [2:0] TGT_PRG_RAM = 3'd1;
   localparam logic [2:0] TGT_CHR     = 3'd2;
   localparam logic [2:0] TGT_REG     = 3'd3;
   localparam logic [2:0] TGT_IGNORED = 3'd4;
   localparam logic [2:0] TGT_FAULT   = 3'd5;

   // Serial register selects (address bits 14..13)
   localparam logic [1:0] REG_CONTROL = 2'd0;
   localparam logic [1:0] REG_CHR_LO  = 2'd1;
   localparam logic [1:0] REG_CHR_HI  = 2'd2;
   localparam logic [1:0] REG_PRG     = 2'd3;

   // Configuration register indexes
   localparam logic CSR_PRG_ROM_BANKS = 1'b0;
   localparam logic CSR_PRG_RAM_MASK  = 1'b1;

   localparam int unsigned CSR_DATA_W = 13;

   // Mapper constants
   localparam logic [31:0] MIN_WRITE_GAP  = 32'd2;
   localparam logic [2:0]  SHIFT_LEN      = 3'd5;
   localparam logic [4:0]  MAX_ROM_BANKS  = 5'd16;
   localparam logic [15:0] ADDR_RAM_BASE  = 16'h6000;
   localparam logic [15:0] ADDR_CHR_LIMIT = 16'h2000;
   localparam logic [1:0]  PRG_MODE_FIRST = 2'd2;
   localparam logic [1:0]  PRG_MODE_LAST  = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] addr;
      logic [7:0]  data;
      logic [31:0] cycle;
   } item_type;

   typedef struct packed {
      logic [2:0]  target;
      logic [17:0] offset;
      logic [1:0]  mirroring;
   } result_type;

   typedef struct packed {
      logic [4:0]  shifter;
      logic [2:0]  shift_count;
      logic [31:0] last_write;
      logic [1:0]  mirror_mode;
      logic [1:0]  prg_mode;
      logic        chr_mode_4k;
      logic [3:0]  prg_bank_reg;
      logic [4:0]  chr_bank_lo;
      logic [4:0]  chr_bank_hi;
   } state_type;

   typedef struct packed {
      logic [4:0]  prg_rom_banks;
      logic [12:0] prg_ram_mask;
   } cfg_type;

endpackage

[sv/sblm_state.sv]
module sblm_state (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                update,
   input  sblm_pkg::state_type                 state_next,
   input  logic                                csr_wen,
   input  logic                                csr_index,
   input  logic [sblm_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output sblm_pkg::state_type                 state,
   output sblm_pkg::cfg_type                   cfg
);
   import sblm_pkg::*;

   state_type state_ff;
   state_type state_in;
   cfg_type   cfg_ff;
   cfg_type   cfg_in;

   // Take the decoded state when an item leaves the input stage
   always_comb begin
      state_in = update ? state_next : state_ff;
   end

   // Apply configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            CSR_PRG_ROM_BANKS: cfg_in.prg_rom_banks = csr_wdata[4:0];
            CSR_PRG_RAM_MASK:  cfg_in.prg_ram_mask  = csr_wdata;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.shifter      <= '0;
         state_ff.shift_count  <= '0;
         state_ff.last_write   <= '0;
         state_ff.mirror_mode  <= '0;
         state_ff.prg_mode     <= PRG_MODE_LAST;
         state_ff.chr_mode_4k  <= 1'b1;
         state_ff.prg_bank_reg <= '0;
         state_ff.chr_bank_lo  <= '0;
         state_ff.chr_bank_hi  <= '0;
         cfg_ff.prg_rom_banks  <= MAX_ROM_BANKS;
         cfg_ff.prg_ram_mask   <= '1;
      end else begin
         state_ff <= state_in;
         cfg_ff   <= cfg_in;
      end
   end

   assign state = state_ff;
   assign cfg   = cfg_ff;

endmodule

[sv/sblm_decode.sv]
module sblm_decode (
   input  sblm_pkg::item_type    item,
   input  sblm_pkg::state_type   state,
   input  sblm_pkg::cfg_type     cfg,
   output sblm_pkg::result_type  result,
   output sblm_pkg::state_type   state_next
);
   import sblm_pkg::*;

   logic [4:0]  bank_count;
   logic [3:0]  rom_bank;
   logic        upper;
   logic [31:0] gap;
   logic [4:0]  shift_new;
   logic [2:0]  count_new;

   // Clamp the ROM size to 1..16 banks
   always_comb begin
      if (cfg.prg_rom_banks == 5'd0) begin
         bank_count = 5'd1;
      end else if (cfg.prg_rom_banks > MAX_ROM_BANKS) begin
         bank_count = MAX_ROM_BANKS;
      end else begin
         bank_count = cfg.prg_rom_banks;
      end
   end

   // Pick the 16 KiB bank for the addressed half of the ROM window
   always_comb begin
      upper = item.addr[14];
      case (state.prg_mode)
         PRG_MODE_FIRST: rom_bank = upper ? state.prg_bank_reg : 4'd0;
         PRG_MODE_LAST:  rom_bank = upper ? 4'(bank_count - 5'd1) : state.prg_bank_reg;
         default:        rom_bank = {state.prg_bank_reg[3:1], upper};
      endcase
   end

   assign gap       = item.cycle - state.last_write;
   assign shift_new = {item.data[0], state.shifter[4:1]};
   assign count_new = state.shift_count + 3'd1;

   // Decode one item and work out the state it leaves
   always_comb begin
      result.target    = TGT_FAULT;
      result.offset    = '0;
      state_next       = state;
      case (item.kind)
         KIND_READ, KIND_WRITE: begin
            if (item.addr < ADDR_RAM_BASE) begin
               result.target = TGT_FAULT;
            end else if (!item.addr[15]) begin
               result.target = TGT_PRG_RAM;
               result.offset = {5'd0, item.addr[12:0] & cfg.prg_ram_mask};
            end else if (item.kind == KIND_READ) begin
               if ({1'b0, rom_bank} >= bank_count) begin
                  result.target = TGT_FAULT;
               end else begin
                  result.target = TGT_PRG_ROM;
                  result.offset = {rom_bank, item.addr[13:0]};
               end
            end else if (gap < MIN_WRITE_GAP) begin
               result.target = TGT_IGNORED;
            end else begin
               result.target         = TGT_REG;
               state_next.last_write = item.cycle;
               if (item.data[7]) begin
                  state_next.shifter     = '0;
                  state_next.shift_count = '0;
                  state_next.prg_mode    = PRG_MODE_LAST;
               end else if (count_new >= SHIFT_LEN) begin
                  // Fifth bit: commit to the register picked by the address
                  case (item.addr[14:13])
                     REG_CONTROL: begin
                        state_next.mirror_mode = shift_new[1:0];
                        state_next.prg_mode    = shift_new[3:2];
                        state_next.chr_mode_4k = shift_new[4];
                     end
                     REG_CHR_LO: state_next.chr_bank_lo  = shift_new;
                     REG_CHR_HI: state_next.chr_bank_hi  = shift_new;
                     default:    state_next.prg_bank_reg = shift_new[3:0];
                  endcase
                  state_next.shifter     = '0;
                  state_next.shift_count = '0;
               end else begin
                  state_next.shifter     = shift_new;
                  state_next.shift_count = count_new;
               end
            end
         end
         KIND_CHR: begin
            if (item.addr < ADDR_CHR_LIMIT) begin
               result.target = TGT_CHR;
               if (!state.chr_mode_4k) begin
                  result.offset = {1'b0, state.chr_bank_lo[4:1], item.addr[12:0]};
               end else if (!item.addr[12]) begin
                  result.offset = {1'b0, state.chr_bank_lo, item.addr[11:0]};
               end else begin
                  result.offset = {1'b0, state.chr_bank_hi, item.addr[11:0]};
               end
            end
         end
         default: begin
            result.target = TGT_FAULT;
         end
      endcase
      result.mirroring = state_next.mirror_mode;
   end

endmodule

[sv/serial_loaded_bank_mapper_top.sv]
// Channel   Direction  Signals
// req       in         req_valid, req_ready, req_kind, req_addr, req_data, req_cycle
// rsp       out        rsp_valid, rsp_ready, rsp_target, rsp_offset, rsp_mirroring
// csr       in         csr_wen, csr_index, csr_wdata
//
// One item per cycle unless a result stalls; items go from input to result register.
// The input register feeds the decode logic, which updates the mapper state and
// loads the result register in the same cycle.
// Reset is synchronous; after reset the mapper is in last-bank-fixed mode.
// A stalled result holds in its register; an empty input register still takes an item.
module serial_loaded_bank_mapper_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_kind,
   input  logic [15:0]                     req_addr,
   input  logic [7:0]                      req_data,
   input  logic [31:0]                     req_cycle,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [2:0]                      rsp_target,
   output logic [17:0]                     rsp_offset,
   output logic [1:0]                      rsp_mirroring,
   input  logic                            csr_wen,
   input  logic                            csr_index,
   input  logic [sblm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sblm_pkg::*;

   item_type   in_ff;
   item_type   in_in;
   logic       in_valid_ff;
   logic       in_valid_in;
   result_type out_ff;
   result_type out_in;
   logic       out_valid_ff;
   logic       out_valid_in;
   logic       advance;
   state_type  state;
   state_type  state_next;
   cfg_type    cfg;
   result_type result;

   // Move the held item into the result register when there is room
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   always_comb begin
      in_in       = in_ff;
      in_valid_in = in_valid_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_in       = '{kind: req_kind, addr: req_addr, data: req_data, cycle: req_cycle};
         in_valid_in = 1'b1;
      end
   end

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_in       = result;
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   sblm_decode u_decode (
      .item       (in_ff),
      .state      (state),
      .cfg        (cfg),
      .result     (result),
      .state_next (state_next)
   );

   sblm_state u_state (
      .clock      (clock),
      .reset      (reset),
      .update     (advance),
      .state_next (state_next),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .state      (state),
      .cfg        (cfg)
   );

   assign rsp_valid     = out_valid_ff;
   assign rsp_target    = out_ff.target;
   assign rsp_offset    = out_ff.offset;
   assign rsp_mirroring = out_ff.mirroring;

endmodule

[sv/sblm_checker.sv]
`include "assert_macros.svh"

module sblm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_target,
   input logic [17:0] rsp_offset,
   input logic [1:0]  rsp_mirroring
);
   import sblm_pkg::*;

   logic [22:0] payload;
   logic        stall;
   logic        accept;
   logic        rsp_bare;
   logic        code_ok;

   // Gather what the ports show for the checks below
   assign payload  = {rsp_target, rsp_offset, rsp_mirroring};
   assign stall    = rsp_valid && !rsp_ready;
   assign accept   = req_valid && req_ready;
   assign rsp_bare = rsp_valid && ((rsp_target == TGT_REG) || (rsp_target == TGT_IGNORED)
                                   || (rsp_target == TGT_FAULT));
   assign code_ok  = (rsp_target <= TGT_FAULT) && (rsp_target != TGT_CHR || !rsp_offset[17]);

   // A stalled result holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, stall, rsp_valid && $stable(payload), "held item changed")

   // An accepted item shows a result after the input and result registers
   `ASSERT_NEXT(a_req_to_rsp, clock, reset, accept, ##1 rsp_valid, "accepted item gave no result")

   // Register, ignored and fault results carry no offset
   `ASSERT_IMPLIES(a_zero_offset, clock, reset, rsp_bare, rsp_offset == '0, "offset on bare result")

   // Targets stay within the defined codes and pattern offsets within 128 KiB
   `ASSERT_IMPLIES(a_target_range, clock, reset, rsp_valid, code_ok, "result code out of range")

endmodule

bind serial_loaded_bank_mapper_top sblm_checker u_checker (.*);

[dv/tb_top.sv]
module tb_top;
   import sblm_pkg::*;

   localparam int          CYCLE_LIMIT   = 300000;
   localparam int          DRAIN_SETTLE  = 4;
   localparam int          LONG_HOLD     = 120;
   localparam int          HOLD_SPACING  = 350;
   localparam int          REPORT_LIMIT  = 10;
   localparam logic [1:0]  KIND_UNUSED   = 2'd3;
   localparam logic [15:0] ADDR_ROM_BASE = 16'h8000;
   localparam logic [15:0] ADDR_UPPER    = 16'hC000;
   localparam logic [15:0] ADDR_CHR_HALF = 16'h1000;

   typedef enum logic [1:0] {STEP_ACCESS, STEP_DRAIN, STEP_CSR} bus_op_e;

   typedef struct {
      bus_op_e                op;
      item_type               access;
      logic                   csr_idx;
      logic [CSR_DATA_W-1:0]  csr_val;
   } bus_step_t;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_valid  = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_kind   = '0;
   logic [15:0]           req_addr   = '0;
   logic [7:0]            req_data   = '0;
   logic [31:0]           req_cycle  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready  = 1'b0;
   logic [2:0]            rsp_target;
   logic [17:0]           rsp_offset;
   logic [1:0]            rsp_mirroring;
   logic                  csr_wen    = 1'b0;
   logic                  csr_index  = 1'b0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Mapper copy kept in step with the accepted items
   state_type  mapper_state;
   cfg_type    mapper_cfg;

   bus_step_t  pending_steps[$];
   result_type expected_results[$];

   logic [31:0] bus_cycle;
   int queued_accesses = 0;
   int accesses_sent   = 0;
   int results_checked = 0;
   int csr_writes      = 0;
   int regs_committed  = 0;
   int writes_ignored  = 0;
   int fail_count      = 0;
   int cycle_count     = 0;
   int send_gap        = 0;
   int send_calm       = 0;
   int settle_count    = 0;
   int recv_calm       = 0;
   int stall_left      = 0;
   int hold_left       = 0;
   int next_hold_mark  = 150;

   serial_loaded_bank_mapper_top uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_addr      (req_addr),
      .req_data      (req_data),
      .req_cycle     (req_cycle),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_target    (rsp_target),
      .rsp_offset    (rsp_offset),
      .rsp_mirroring (rsp_mirroring),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Decode one bus access and advance the mapper copy
   function automatic result_type decode_access(item_type acc);
      result_type res;
      logic [4:0] bank_count;
      logic [4:0] bank;
      logic       upper;
      res.target = TGT_FAULT;
      res.offset = '0;
      if (mapper_cfg.prg_rom_banks == 5'd0) bank_count = 5'd1;
      else if (mapper_cfg.prg_rom_banks > MAX_ROM_BANKS) bank_count = MAX_ROM_BANKS;
      else bank_count = mapper_cfg.prg_rom_banks;

      if (acc.kind == KIND_READ || acc.kind == KIND_WRITE) begin
         if (acc.addr < ADDR_RAM_BASE) begin
            res.target = TGT_FAULT;
         end else if (acc.addr < ADDR_ROM_BASE) begin
            res.target = TGT_PRG_RAM;
            res.offset = {5'd0, acc.addr[12:0] & mapper_cfg.prg_ram_mask};
         end else if (acc.kind == KIND_READ) begin
            upper = (acc.addr >= ADDR_UPPER);
            case (mapper_state.prg_mode)
               PRG_MODE_FIRST: bank = upper ? {1'b0, mapper_state.prg_bank_reg} : 5'd0;
               PRG_MODE_LAST:  bank = upper ? bank_count - 5'd1
                                            : {1'b0, mapper_state.prg_bank_reg};
               default:        bank = {1'b0, mapper_state.prg_bank_reg[3:1], upper};
            endcase
            if (bank < bank_count) begin
               res.target = TGT_PRG_ROM;
               res.offset = {bank[3:0], acc.addr[13:0]};
            end
         end else if (acc.cycle - mapper_state.last_write < MIN_WRITE_GAP) begin
            res.target = TGT_IGNORED;
            writes_ignored++;
         end else begin
            mapper_state.last_write = acc.cycle;
            res.target = TGT_REG;
            if (acc.data[7]) begin
               mapper_state.shifter     = '0;
               mapper_state.shift_count = '0;
               mapper_state.prg_mode    = PRG_MODE_LAST;
            end else begin
               mapper_state.shifter     = {acc.data[0], mapper_state.shifter[4:1]};
               mapper_state.shift_count = mapper_state.shift_count + 3'd1;
               if (mapper_state.shift_count >= SHIFT_LEN) begin
                  // Fifth bit: commit to the register picked by address bits 14..13
                  case (acc.addr[14:13])
                     REG_CONTROL: begin
                        mapper_state.mirror_mode = mapper_state.shifter[1:0];
                        mapper_state.prg_mode    = mapper_state.shifter[3:2];
                        mapper_state.chr_mode_4k = mapper_state.shifter[4];
                     end
                     REG_CHR_LO: mapper_state.chr_bank_lo  = mapper_state.shifter;
                     REG_CHR_HI: mapper_state.chr_bank_hi  = mapper_state.shifter;
                     default:    mapper_state.prg_bank_reg = mapper_state.shifter[3:0];
                  endcase
                  mapper_state.shifter     = '0;
                  mapper_state.shift_count = '0;
                  regs_committed++;
               end
            end
         end
      end else if (acc.kind == KIND_CHR) begin
         if (acc.addr < ADDR_CHR_LIMIT) begin
            res.target = TGT_CHR;
            if (!mapper_state.chr_mode_4k)
               res.offset = {1'b0, mapper_state.chr_bank_lo[4:1], 13'd0} + {5'd0, acc.addr[12:0]};
            else if (acc.addr < ADDR_CHR_HALF)
               res.offset = {1'b0, mapper_state.chr_bank_lo, acc.addr[11:0]};
            else
               res.offset = {1'b0, mapper_state.chr_bank_hi, acc.addr[11:0]};
         end
      end
      res.mirroring = mapper_state.mirror_mode;
      return res;
   endfunction

   // Mostly short gaps, a few long ones, and now and then a stretch with none
   function automatic int pick_gap(inout int calm_left);
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (r < 62) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 25);
   endfunction

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) $display("%s", msg);
   endfunction

   task automatic queue_access(input logic [1:0] kind, input logic [15:0] addr,
                               input logic [7:0] data, input int unsigned gap);
      bus_step_t s;
      bus_cycle      = bus_cycle + gap;
      s.op           = STEP_ACCESS;
      s.access.kind  = kind;
      s.access.addr  = addr;
      s.access.data  = data;
      s.access.cycle = bus_cycle;
      s.csr_idx      = 1'b0;
      s.csr_val      = '0;
      pending_steps.push_back(s);
      queued_accesses++;
   endtask

   task automatic queue_control(input bus_op_e op, input logic idx,
                                input logic [CSR_DATA_W-1:0] val);
      bus_step_t s;
      s.op      = op;
      s.access  = '0;
      s.csr_idx = idx;
      s.csr_val = val;
      pending_steps.push_back(s);
   endtask

   task automatic queue_setting(input int banks, input logic [12:0] mask);
      // junk above the 5-bit bank field must be dropped by the block
      queue_control(STEP_CSR, CSR_PRG_ROM_BANKS, {8'($urandom), 5'(banks)});
      queue_control(STEP_CSR, CSR_PRG_RAM_MASK, mask);
   endtask

   // Shift in a 5-bit value one bit per write; scattered loads vary the early
   // addresses and slip in pattern fetches, which must not disturb the shifter
   task automatic queue_serial_load(input logic [15:0] addr, input logic [4:0] value,
                                    input bit scatter, input int writes);
      logic [7:0]  data;
      logic [15:0] a;
      for (int i = 0; i < writes; i++) begin
         data    = 8'($urandom_range(0, 127));
         data[0] = value[i];
         a       = (scatter && i < 4) ? (ADDR_ROM_BASE | 16'($urandom)) : addr;
         if (scatter && $urandom_range(0, 3) == 0)
            queue_access(KIND_CHR, 16'($urandom_range(0, 32'h1FFF)), 8'($urandom), 1);
         queue_access(KIND_WRITE, a, data, $urandom_range(2, 6));
      end
   endtask

   task automatic queue_traffic(input int count);
      int          stop_at;
      int          r;
      int          writes;
      logic [15:0] a;
      stop_at = queued_accesses + count;
      while (queued_accesses < stop_at) begin
         if ($urandom_range(0, 39) == 0) bus_cycle = $urandom;
         else if ($urandom_range(0, 99) == 0) bus_cycle = 32'hFFFF_FFFD;
         r = $urandom_range(0, 99);
         if (r < 35) begin
            // serial load, sometimes cut short and cleared
            if ($urandom_range(0, 1) == 1)
               queue_access(KIND_WRITE, ADDR_ROM_BASE | 16'($urandom), 8'h80 | 8'($urandom),
                            $urandom_range(2, 5));
            writes = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4) : 5;
            queue_serial_load(ADDR_ROM_BASE | 16'($urandom), 5'($urandom), 1'b1, writes);
         end else if (r < 58) begin
            r = $urandom_range(0, 9);
            if (r < 7) a = ADDR_ROM_BASE | 16'($urandom);
            else if (r < 8) a = ADDR_RAM_BASE + 16'($urandom_range(0, 32'h1FFF));
            else a = 16'($urandom);
            queue_access(KIND_READ, a, 8'($urandom), $urandom_range(1, 3));
         end else if (r < 78) begin
            a = ($urandom_range(0, 9) < 9) ? 16'($urandom_range(0, 32'h1FFF)) : 16'($urandom);
            queue_access(KIND_CHR, a, 8'($urandom), $urandom_range(1, 3));
         end else if (r < 85) begin
            queue_access(KIND_WRITE, ADDR_RAM_BASE + 16'($urandom_range(0, 32'h1FFF)),
                         8'($urandom), $urandom_range(0, 3));
         end else if (r < 92) begin
            // stray register writes, often too close together
            queue_access(KIND_WRITE, ADDR_ROM_BASE | 16'($urandom), 8'($urandom),
                         $urandom_range(0, 3));
         end else if (r < 96) begin
            queue_access(2'($urandom_range(0, 1)), 16'($urandom_range(0, 32'h5FFF)),
                         8'($urandom), $urandom_range(0, 3));
         end else begin
            queue_access(KIND_UNUSED, 16'($urandom), 8'($urandom), 1);
         end
      end
   endtask

   // Stimulus plan and end of run
   initial begin
      mapper_state              = '0;
      mapper_state.prg_mode     = PRG_MODE_LAST;
      mapper_state.chr_mode_4k  = 1'b1;
      mapper_cfg.prg_rom_banks  = MAX_ROM_BANKS;
      mapper_cfg.prg_ram_mask   = 13'h1FFF;
      bus_cycle                 = '0;

      // Directed: decode regions at reset settings, writes too soon after reset
      queue_access(KIND_READ,   16'h0000,      8'h00, 0);
      queue_access(KIND_WRITE,  16'h5FFF,      8'hFF, 0);
      queue_access(KIND_READ,   ADDR_RAM_BASE, 8'h00, 0);
      queue_access(KIND_WRITE,  16'h7FFF,      8'h80, 0);
      queue_access(KIND_WRITE,  ADDR_ROM_BASE, 8'h01, 0);
      queue_access(KIND_WRITE,  16'hFFFF,      8'h80, 1);
      queue_access(KIND_READ,   16'hFFFF,      8'h00, 1);
      queue_access(KIND_CHR,    16'h1FFF,      8'h00, 1);
      queue_access(KIND_CHR,    ADDR_CHR_LIMIT, 8'h00, 1);
      queue_access(KIND_UNUSED, ADDR_ROM_BASE, 8'h80, 1);
      queue_access(KIND_WRITE,  ADDR_UPPER,    8'h80, 2);
      // control: vertical mirroring, 32K program banks, 8K pattern bank
      queue_serial_load(ADDR_ROM_BASE, 5'b00110, 1'b0, 5);
      queue_serial_load(16'hE000, 5'h1F, 1'b0, 5);
      queue_access(KIND_READ,   ADDR_ROM_BASE, 8'h00, 1);
      queue_access(KIND_READ,   ADDR_UPPER,    8'h00, 1);
      queue_access(KIND_CHR,    16'h1FFF,      8'h00, 1);
      queue_access(KIND_WRITE,  ADDR_ROM_BASE, 8'h01, 0);

      // Random traffic under a range of bank counts and RAM masks
      queue_setting(1, 13'h0000);
      queue_traffic(100);
      queue_setting(0, 13'h07FF);
      queue_traffic(100);
      queue_setting(31, 13'($urandom));
      queue_traffic(50);
      queue_control(STEP_DRAIN, 1'b0, '0);
      queue_traffic(50);
      queue_setting(17, 13'h1FFF);
      queue_traffic(100);
      queue_setting(16, 13'h003F);
      queue_traffic(100);
      repeat (2) begin
         queue_setting($urandom_range(1, 16), 13'((1 << $urandom_range(0, 13)) - 1));
         queue_traffic(100);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_steps.size() != 0 || req_valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Covered %0d accesses, %0d serial register loads, %0d writes dropped as too soon",
               accesses_sent, regs_committed, writes_ignored);
      $display("across %0d configuration writes; %0d results checked, %0d failures",
               csr_writes, results_checked, fail_count);
      if (fail_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

   // Drive accesses and configuration writes from the pending queue
   always @(posedge clock) begin : access_drive
      logic                  nxt_valid;
      item_type              nxt_item;
      logic                  nxt_wen;
      logic                  nxt_idx;
      logic [CSR_DATA_W-1:0] nxt_wdata;
      bus_step_t             nxt_step;
      nxt_valid = req_valid;
      nxt_item  = {req_kind, req_addr, req_data, req_cycle};
      nxt_wen   = 1'b0;
      nxt_idx   = csr_index;
      nxt_wdata = csr_wdata;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_results.push_back(decode_access(nxt_item));
            accesses_sent++;
            nxt_valid = 1'b0;
            send_gap  = pick_gap(send_calm);
         end
         if (!nxt_valid && pending_steps.size() != 0) begin
            nxt_step = pending_steps[0];
            if (send_gap > 0) begin
               send_gap--;
            end else if (nxt_step.op == STEP_ACCESS) begin
               nxt_valid = 1'b1;
               nxt_item  = nxt_step.access;
               void'(pending_steps.pop_front());
            end else begin
               // hold until the block has drained, then let it settle
               if (expected_results.size() == 0 && !rsp_valid) settle_count++;
               else settle_count = 0;
               if (settle_count >= DRAIN_SETTLE) begin
                  settle_count = 0;
                  if (nxt_step.op == STEP_CSR) begin
                     nxt_wen   = 1'b1;
                     nxt_idx   = nxt_step.csr_idx;
                     nxt_wdata = nxt_step.csr_val;
                     if (nxt_step.csr_idx == CSR_PRG_ROM_BANKS)
                        mapper_cfg.prg_rom_banks = nxt_step.csr_val[4:0];
                     else
                        mapper_cfg.prg_ram_mask = nxt_step.csr_val;
                     csr_writes++;
                  end
                  void'(pending_steps.pop_front());
               end
            end
         end
      end
      req_valid <= nxt_valid;
      req_kind  <= nxt_item.kind;
      req_addr  <= nxt_item.addr;
      req_data  <= nxt_item.data;
      req_cycle <= nxt_item.cycle;
      csr_wen   <= nxt_wen;
      csr_index <= nxt_idx;
      csr_wdata <= nxt_wdata;
   end

   // Check each result against the oldest expectation and pace rsp_ready
   always @(posedge clock) begin : result_watch
      logic       nxt_ready;
      result_type want;
      int         gap;
      nxt_ready = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (expected_results.size() == 0) begin
               note_failure($sformatf("unexpected result: target %0d offset 0x%05h mirroring %0d",
                                      rsp_target, rsp_offset, rsp_mirroring));
            end else begin
               want = expected_results.pop_front();
               if (rsp_target !== want.target || rsp_offset !== want.offset ||
                   rsp_mirroring !== want.mirroring)
                  note_failure($sformatf({"result %0d mismatch: expected target %0d ",
                                          "offset 0x%05h mirroring %0d, got target %0d ",
                                          "offset 0x%05h mirroring %0d"},
                                         results_checked, want.target, want.offset,
                                         want.mirroring, rsp_target, rsp_offset,
                                         rsp_mirroring));
            end
         end
         // long hold-off so the block backs up and stalls its input
         if (results_checked >= next_hold_mark) begin
            hold_left      = LONG_HOLD;
            next_hold_mark = next_hold_mark + HOLD_SPACING;
         end
         if (hold_left > 0) begin
            hold_left--;
         end else if (stall_left > 0) begin
            stall_left--;
         end else begin
            gap = pick_gap(recv_calm);
            if (gap == 0) nxt_ready = 1'b1;
            else stall_left = gap - 1;
         end
      end
      rsp_ready <= nxt_ready;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("Regression FAIL");
         $finish;
      end
   end

endmodule
